// ===== hw/rtl/pbm_pkg.sv =====
package pbm_pkg;

    localparam int NUM_PAGES   = 65536;
    localparam int PAGE_BYTES  = 4096;
    localparam int WORD_BITS   = 64;
    localparam int BIT_W       = 6;
    localparam int WORDS       = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PAGE_W      = WADDR_W + BIT_W;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int SUM_W       = 21;
    localparam int WIDE_W      = 64;

    localparam int CMD_W       = 2;
    localparam int IDX_W       = 16;
    localparam int CNT_W       = 17;
    localparam int ADDR_W      = 28;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_USED  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic run;
        logic out_load;
    } t_dp_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             clr_last;
        logic             rng_last;
        logic             alloc_done;
    } t_dp_sts;

endpackage

// ===== hw/rtl/page_bitmap_allocator.sv =====
// channel   dir  fields (from bit 0)
// s_axis    in   tuser: command[1:0]; tdata: page_index[15:0], page_count[32:16]
// m_axis    out  tdata: page_address[27:0], success[28]
//
// after reset the bitmap is filled with used marks, one word a cycle,
// with s_axis_tready low until the last word is written
// range commands work through each touched 64-page word in turn;
// allocate scans words upward from word 0 until it finds a free page or reaches the last word
// the bitmap memory port gives one word read and one word written per cycle
// one word is worked on at a time; a finished result waits in the output register
module page_bitmap_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // page_index, page_count
    input  logic [pbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command
    input  logic [pbm_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // page_address, success
    output logic [pbm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    pbm_pkg::t_dp_ctl                w_ctl;
    pbm_pkg::t_dp_sts                w_sts;
    logic [pbm_pkg::ADDR_W-1:0]      w_page_address;
    logic                            w_success;

    pbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (w_ctl),
        .i_sts       (w_sts)
    );

    pbm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .i_command      (s_axis_tuser),
        .i_page_index   (s_axis_tdata[15:0]),
        .i_page_count   (s_axis_tdata[32:16]),
        .o_page_address (w_page_address),
        .o_success      (w_success)
    );

    assign m_axis_tdata = {3'b000, w_success, w_page_address};

endmodule

// ===== hw/rtl/pbm_ram.sv =====
module pbm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pbm_datapath.sv =====
module pbm_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pbm_pkg::t_dp_ctl              i_ctl,
    output pbm_pkg::t_dp_sts              o_sts,
    input  logic [pbm_pkg::CMD_W-1:0]     i_command,
    input  logic [pbm_pkg::IDX_W-1:0]     i_page_index,
    input  logic [pbm_pkg::CNT_W-1:0]     i_page_count,
    output logic [pbm_pkg::ADDR_W-1:0]    o_page_address,
    output logic                          o_success
);

    localparam logic [pbm_pkg::WADDR_W-1:0] LAST_W = pbm_pkg::WADDR_W'(pbm_pkg::WORDS - 1);

    logic [pbm_pkg::WADDR_W-1:0]   r_ra;
    logic [pbm_pkg::WADDR_W-1:0]   r_pa;
    logic [pbm_pkg::WADDR_W-1:0]   r_first_w;
    logic [pbm_pkg::WADDR_W-1:0]   r_last_w;
    logic [pbm_pkg::BIT_W-1:0]     r_first_b;
    logic [pbm_pkg::BIT_W-1:0]     r_last_b;
    logic                          r_issue;
    logic                          r_pv;
    logic [pbm_pkg::CMD_W-1:0]     r_cmd;
    logic                          r_empty;
    logic [pbm_pkg::ADDR_W-1:0]    r_res_addr;
    logic                          r_res_ok;
    logic [pbm_pkg::ADDR_W-1:0]    r_out_addr;
    logic                          r_out_ok;

    logic [pbm_pkg::SUM_W-1:0]     w_first;
    logic [pbm_pkg::SUM_W-1:0]     w_end_raw;
    logic [pbm_pkg::SUM_W-1:0]     w_end;
    logic [pbm_pkg::SUM_W-1:0]     w_last;
    logic                          w_empty;
    logic                          w_in_alloc;
    logic                          w_in_rng;

    logic                          w_is_rng;
    logic                          w_is_alloc;
    logic                          w_issue;
    logic [pbm_pkg::WADDR_W-1:0]   w_stop;

    logic [pbm_pkg::WORD_BITS-1:0] w_rd;
    logic [pbm_pkg::WORD_BITS-1:0] w_free;
    logic [pbm_pkg::WORD_BITS-1:0] w_low;
    logic                          w_any;
    logic [pbm_pkg::BIT_W-1:0]     w_bit;
    logic [pbm_pkg::PAGE_W-1:0]    w_page;
    logic                          w_page_ok;
    logic                          w_alloc_hit;
    logic [pbm_pkg::WIDE_W-1:0]    w_page_wide;
    logic [pbm_pkg::ADDR_W-1:0]    w_addr;

    logic [pbm_pkg::BIT_W-1:0]     w_lo;
    logic [pbm_pkg::BIT_W-1:0]     w_hi;
    logic [pbm_pkg::WORD_BITS-1:0] w_mask;
    logic [pbm_pkg::WORD_BITS-1:0] w_rng_data;

    logic                          w_we;
    logic [pbm_pkg::WADDR_W-1:0]   w_waddr;
    logic [pbm_pkg::WORD_BITS-1:0] w_wdata;
    logic                          w_alloc_wr;

    // range bounds of the incoming word, clipped to the bitmap
    always_comb begin
        w_first   = pbm_pkg::SUM_W'(i_page_index);
        w_end_raw = w_first + pbm_pkg::SUM_W'(i_page_count);
        w_end     = (w_end_raw > pbm_pkg::SUM_W'(pbm_pkg::NUM_PAGES))
                  ? pbm_pkg::SUM_W'(pbm_pkg::NUM_PAGES) : w_end_raw;
        w_empty   = (w_end <= w_first);
        w_last    = w_end - pbm_pkg::SUM_W'(1);
    end

    assign w_in_alloc = (i_command == pbm_pkg::CMD_ALLOC);
    assign w_in_rng   = (i_command == pbm_pkg::CMD_USED) || (i_command == pbm_pkg::CMD_FREE);

    assign w_is_rng   = (r_cmd == pbm_pkg::CMD_USED) || (r_cmd == pbm_pkg::CMD_FREE);
    assign w_is_alloc = (r_cmd == pbm_pkg::CMD_ALLOC);
    assign w_issue    = i_ctl.run && r_issue;
    assign w_stop     = w_is_alloc ? LAST_W : r_last_w;

    // lowest free page in the returned word
    always_comb begin
        w_free = ~w_rd;
        w_low  = w_free & (~w_free + pbm_pkg::WORD_BITS'(1));
        w_any  = |w_free;
        w_bit  = '0;
        for (int i = 0; i < pbm_pkg::WORD_BITS; i++) begin
            if (w_low[i]) begin
                w_bit = w_bit | pbm_pkg::BIT_W'(i);
            end
        end
    end

    assign w_page      = {r_pa, w_bit};
    assign w_page_ok   = pbm_pkg::SUM_W'(w_page) < pbm_pkg::SUM_W'(pbm_pkg::NUM_PAGES);
    assign w_alloc_hit = w_any && w_page_ok;
    assign w_page_wide = pbm_pkg::WIDE_W'(w_page) << pbm_pkg::PAGE_SHIFT;
    assign w_addr      = w_page_wide[pbm_pkg::ADDR_W-1:0];

    // bit mask of the range inside the current word
    always_comb begin
        w_lo   = (r_pa == r_first_w) ? r_first_b : '0;
        w_hi   = (r_pa == r_last_w) ? r_last_b : '1;
        w_mask = ({pbm_pkg::WORD_BITS{1'b1}} << w_lo) & ({pbm_pkg::WORD_BITS{1'b1}} >> (~w_hi));
        w_rng_data = (r_cmd == pbm_pkg::CMD_USED) ? (w_rd | w_mask) : (w_rd & ~w_mask);
    end

    assign w_alloc_wr = i_ctl.run && r_pv && w_is_alloc && w_alloc_hit;
    assign w_we       = i_ctl.clr || (i_ctl.run && r_pv && w_is_rng) || w_alloc_wr;
    assign w_waddr    = i_ctl.clr ? r_ra : r_pa;
    assign w_wdata    = i_ctl.clr ? {pbm_pkg::WORD_BITS{1'b1}}
                      : (w_is_rng ? w_rng_data : (w_rd | w_low));

    pbm_ram #(
        .WIDTH (pbm_pkg::WORD_BITS),
        .DEPTH (pbm_pkg::WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ra),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra    <= '0;
            r_issue <= 1'b0;
            r_pv    <= 1'b0;
        end else if (i_ctl.load) begin
            r_ra    <= w_in_alloc ? '0 : pbm_pkg::WADDR_W'(w_first >> pbm_pkg::BIT_W);
            r_issue <= w_in_alloc || (w_in_rng && !w_empty);
            r_pv    <= 1'b0;
        end else if (i_ctl.clr) begin
            r_ra <= r_ra + pbm_pkg::WADDR_W'(1);
            r_pv <= 1'b0;
        end else if (i_ctl.run) begin
            r_pv <= w_issue;
            if (w_issue) begin
                if (r_ra == w_stop) begin
                    r_issue <= 1'b0;
                end else begin
                    r_ra <= r_ra + pbm_pkg::WADDR_W'(1);
                end
            end
        end else begin
            r_pv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_pa <= r_ra;
        end
        if (i_ctl.load) begin
            r_cmd      <= i_command;
            r_empty    <= w_empty;
            r_first_w  <= pbm_pkg::WADDR_W'(w_first >> pbm_pkg::BIT_W);
            r_first_b  <= w_first[pbm_pkg::BIT_W-1:0];
            r_last_w   <= pbm_pkg::WADDR_W'(w_last >> pbm_pkg::BIT_W);
            r_last_b   <= w_last[pbm_pkg::BIT_W-1:0];
            r_res_addr <= '0;
            r_res_ok   <= w_in_rng;
        end else if (w_alloc_wr) begin
            r_res_addr <= w_addr;
            r_res_ok   <= 1'b1;
        end
        if (i_ctl.out_load) begin
            r_out_addr <= r_res_addr;
            r_out_ok   <= r_res_ok;
        end
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.empty      = r_empty;
        o_sts.clr_last   = i_ctl.clr && (r_ra == LAST_W);
        o_sts.rng_last   = i_ctl.run && r_pv && w_is_rng && (r_pa == r_last_w);
        o_sts.alloc_done = i_ctl.run && r_pv && w_is_alloc && (w_any || (r_pa == LAST_W));
    end

    assign o_page_address = r_out_addr;
    assign o_success      = r_out_ok;

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_issue) |-> (w_waddr != r_ra))
        else $error("write collides with read issued in the same cycle");

    a_alloc_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alloc_wr |-> $onehot(w_wdata ^ w_rd))
        else $error("allocate must set exactly one page bit");

    a_pv_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> $past(i_ctl.run))
        else $error("read data marked valid without a scan running");

endmodule

// ===== hw/rtl/pbm_ctrl.sv =====
module pbm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pbm_pkg::t_dp_ctl o_ctl,
    input  pbm_pkg::t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DEC,
        S_RANGE,
        S_ALLOC,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_ctl.clr      = (r_state == S_INIT);
        o_ctl.load     = (r_state == S_IDLE) && i_in_valid;
        o_ctl.run      = (r_state == S_RANGE) || (r_state == S_ALLOC);
        o_ctl.out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    case (i_sts.cmd)
                        pbm_pkg::CMD_USED, pbm_pkg::CMD_FREE: begin
                            r_state <= i_sts.empty ? S_DONE : S_RANGE;
                        end
                        pbm_pkg::CMD_ALLOC: begin
                            r_state <= S_ALLOC;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_RANGE: begin
                    if (i_sts.rng_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_ALLOC: begin
                    if (i_sts.alloc_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_rng_last_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.rng_last |-> (r_state == S_RANGE))
        else $error("range write-back finished outside the range phase");

    a_alloc_in_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.alloc_done |-> (r_state == S_ALLOC))
        else $error("allocate search finished outside the allocate phase");

    a_no_out_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !r_out_valid)
        else $error("result presented during bitmap initialization");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam logic [pbm_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int RANDOM_WORDS = 500;
    localparam int DRAIN_CYCLES = 1100;

    typedef struct {
        logic [pbm_pkg::ADDR_W-1:0] page_address;
        logic                       success;
    } t_alloc_reply;

    class page_map_scoreboard;
        bit [pbm_pkg::WORD_BITS-1:0] used_words [pbm_pkg::WORDS];
        t_alloc_reply                pending_replies [$];
        int                          mismatches;

        function new();
            mismatches = 0;
            foreach (used_words[w]) used_words[w] = '1;
        endfunction

        function void note_command(logic [pbm_pkg::CMD_W-1:0] cmd,
                                   logic [pbm_pkg::IDX_W-1:0] first,
                                   logic [pbm_pkg::CNT_W-1:0] count);
            t_alloc_reply reply;
            int unsigned  stop;
            int unsigned  p;
            int unsigned  w;
            int unsigned  b;
            bit           searching;
            logic [63:0]  byte_addr;
            reply.page_address = '0;
            reply.success = 1'b0;
            if (cmd == pbm_pkg::CMD_USED || cmd == pbm_pkg::CMD_FREE) begin
                stop = int'(first) + int'(count);
                if (stop > pbm_pkg::NUM_PAGES) stop = pbm_pkg::NUM_PAGES;
                for (p = first; p < stop; p++)
                    used_words[p / pbm_pkg::WORD_BITS][p % pbm_pkg::WORD_BITS] =
                        (cmd == pbm_pkg::CMD_USED);
                reply.success = 1'b1;
            end else if (cmd == pbm_pkg::CMD_ALLOC) begin
                searching = 1'b1;
                for (w = 0; w < pbm_pkg::WORDS && searching; w++) begin
                    if (~used_words[w] != '0) begin
                        searching = 1'b0;
                        b = 0;
                        while (used_words[w][b]) b++;
                        p = w * pbm_pkg::WORD_BITS + b;
                        if (p < pbm_pkg::NUM_PAGES) begin
                            used_words[w][b] = 1'b1;
                            byte_addr = 64'(p) * 64'(pbm_pkg::PAGE_BYTES);
                            reply.page_address = byte_addr[pbm_pkg::ADDR_W-1:0];
                            reply.success = 1'b1;
                        end
                    end
                end
            end
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(logic [pbm_pkg::ADDR_W-1:0] page_address, logic success);
            t_alloc_reply want;
            if (pending_replies.size() == 0) begin
                $error("unexpected word: page_address %0h success %0b", page_address, success);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (page_address !== want.page_address) begin
                    $error("page_address: expected %0h, got %0h", want.page_address,
                           page_address);
                    mismatches++;
                end
                if (success !== want.success) begin
                    $error("success: expected %0b, got %0b", want.success, success);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [pbm_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [pbm_pkg::CMD_W-1:0]       s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [pbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    page_map_scoreboard sb;
    bit                 tx_steady;
    bit                 rx_steady;
    int unsigned        rx_hold;

    page_bitmap_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic [pbm_pkg::CMD_W-1:0] cmd,
                             input logic [pbm_pkg::IDX_W-1:0] idx,
                             input logic [pbm_pkg::CNT_W-1:0] cnt);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) tx_steady = ~tx_steady;
        gap = pick_gap(tx_steady);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {7'b0, cnt, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, idx, cnt);
        @(negedge i_clk);
    endtask

    // mostly small ranges, half of them near the bottom, so allocations keep hitting freed pages
    task automatic send_random_word();
        int unsigned               r;
        logic [pbm_pkg::IDX_W-1:0] idx;
        logic [pbm_pkg::CNT_W-1:0] cnt;
        r = $urandom_range(0, 99);
        idx = ($urandom_range(0, 1) != 0) ? pbm_pkg::IDX_W'($urandom_range(0, 2047))
                                          : pbm_pkg::IDX_W'($urandom);
        cnt = pbm_pkg::CNT_W'($urandom_range(1, 130));
        if (r < 40) begin
            send_word(pbm_pkg::CMD_ALLOC, pbm_pkg::IDX_W'($urandom),
                      pbm_pkg::CNT_W'($urandom));
        end else if (r < 70) begin
            send_word(pbm_pkg::CMD_FREE, idx, cnt);
        end else if (r < 86) begin
            send_word(pbm_pkg::CMD_USED, idx, cnt);
        end else if (r < 91) begin
            send_word(($urandom_range(0, 1) != 0) ? pbm_pkg::CMD_FREE : pbm_pkg::CMD_USED,
                      pbm_pkg::IDX_W'($urandom),
                      pbm_pkg::CNT_W'($urandom_range(0, 131071)));
        end else if (r < 93) begin
            send_word(($urandom_range(0, 1) != 0) ? pbm_pkg::CMD_FREE : pbm_pkg::CMD_USED,
                      idx, '0);
        end else if (r < 95) begin
            send_word(pbm_pkg::CMD_USED, '0, pbm_pkg::CNT_W'(pbm_pkg::NUM_PAGES));
        end else if (r < 97) begin
            send_word(CMD_UNKNOWN, pbm_pkg::IDX_W'($urandom), pbm_pkg::CNT_W'($urandom));
        end else begin
            send_word(pbm_pkg::CMD_FREE, pbm_pkg::IDX_W'($urandom_range(0, 4095)),
                      pbm_pkg::CNT_W'(pbm_pkg::NUM_PAGES));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_reply(m_axis_tdata[pbm_pkg::ADDR_W-1:0], m_axis_tdata[pbm_pkg::ADDR_W]);
    end

    initial begin
        m_axis_tready = 1'b0;
        rx_steady = 1'b0;
        rx_hold = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 499) == 0) rx_steady = ~rx_steady;
            if (rx_hold != 0) begin
                m_axis_tready = 1'b0;
                rx_hold--;
            end else begin
                m_axis_tready = 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 20)
                    rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(1, 3);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        sb = new();
        tx_steady = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // everything starts used
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        send_word(CMD_UNKNOWN, '1, '1);
        send_word(pbm_pkg::CMD_FREE, '0, '0);
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        // only the top page free
        send_word(pbm_pkg::CMD_FREE, 16'hFFFF, 17'd1);
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        send_word(pbm_pkg::CMD_FREE, '0, pbm_pkg::CNT_W'(pbm_pkg::NUM_PAGES));
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        // ranges running past the end
        send_word(pbm_pkg::CMD_USED, 16'd65000, '1);
        send_word(pbm_pkg::CMD_USED, '0, pbm_pkg::CNT_W'(pbm_pkg::NUM_PAGES));
        send_word(pbm_pkg::CMD_FREE, 16'd64, 17'd64);
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        send_word(pbm_pkg::CMD_FREE, 16'd63, 17'd2);
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        send_word(pbm_pkg::CMD_FREE, 16'hFFFF, '1);
        send_word(pbm_pkg::CMD_USED, '0, 17'd65535);
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);
        send_word(pbm_pkg::CMD_FREE, 16'd130, 17'd1);
        send_word(pbm_pkg::CMD_ALLOC, '1, '1);
        send_word(pbm_pkg::CMD_FREE, 16'd1000, 17'd3000);
        send_word(pbm_pkg::CMD_USED, 16'd1000, 17'd2999);
        send_word(pbm_pkg::CMD_ALLOC, '0, '0);

        repeat (RANDOM_WORDS) send_random_word();
        s_axis_tvalid = 1'b0;

        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/pbm_pkg.sv
hw/rtl/pbm_ram.sv
hw/rtl/pbm_datapath.sv
hw/rtl/pbm_ctrl.sv
hw/rtl/page_bitmap_allocator.sv
tb/sv/tb.sv
